// ===== sv/sbc_pkg.sv =====
// sbc_pkg: shared constants, types and control structs for the simon 128/256 cipher
// no dependencies; imported by the interfaces and every module of the block

package sbc_pkg;

  localparam int WORD_BITS      = 64;
  localparam int ROUNDS         = 72;
  localparam int KEY_WORDS      = 4;
  localparam int Z_LEN          = 62;
  localparam int ADDR_BITS      = $clog2(ROUNDS);
  localparam int ZIDX_BITS      = $clog2(Z_LEN);
  localparam int CFG_INDEX_BITS = 8;

  localparam logic [WORD_BITS-1:0] Z4_SEQ      = 64'hfdc94c3a046d678b;
  localparam logic [WORD_BITS-1:0] ROUND_CONST = 64'd3;

  localparam logic [CFG_INDEX_BITS-1:0] REG_KEY_WORD0 = 8'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_KEY_WORD1 = 8'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_KEY_WORD2 = 8'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_KEY_WORD3 = 8'd3;

  typedef logic [WORD_BITS-1:0]                  word_t;
  typedef logic [ADDR_BITS-1:0]                  addr_t;
  typedef logic [KEY_WORDS-1:0][WORD_BITS-1:0]   key_words_t;

  typedef struct packed {
    logic  load;
    logic  swap;
    logic  step;
    logic  last;
    logic  key_rd;
    addr_t key_addr;
    logic  key_wr;
    addr_t wr_addr;
  } rnd_ctrl_t;

endpackage

// ===== sv/sbc_ifs.sv =====
// sbc_ifs: valid/ready channel interfaces for blocks, results and key configuration
// depends on sbc_pkg for word and index widths

interface sbc_blk_if;
  import sbc_pkg::*;
  logic  valid;
  logic  ready;
  logic  operation;
  word_t block_high;
  word_t block_low;
  modport source (output valid, operation, block_high, block_low, input ready);
  modport sink   (input valid, operation, block_high, block_low, output ready);
endinterface

interface sbc_res_if;
  import sbc_pkg::*;
  logic  valid;
  logic  ready;
  word_t result_high;
  word_t result_low;
  modport source (output valid, result_high, result_low, input ready);
  modport sink   (input valid, result_high, result_low, output ready);
endinterface

interface sbc_cfg_if;
  import sbc_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  word_t                     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/sbc_ksched.sv =====
// sbc_ksched: key expansion window, produces one round key word per step
// depends on sbc_pkg for the z4 sequence and word types

module sbc_ksched (
  input  logic               clk,
  input  logic               load,
  input  logic               step,
  input  sbc_pkg::key_words_t key_words,
  output sbc_pkg::word_t     key_word
);
  import sbc_pkg::*;

  word_t                w0, w1, w2, w3;
  logic [ZIDX_BITS-1:0] zidx;
  word_t                t_a, t_b, w_next;

  always_comb begin
    t_a    = {w3[2:0], w3[WORD_BITS-1:3]} ^ w1;
    t_b    = t_a ^ {t_a[0], t_a[WORD_BITS-1:1]};
    w_next = ~w0 ^ t_b ^ word_t'(Z4_SEQ[zidx]) ^ ROUND_CONST;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      w0   <= key_words[0];
      w1   <= key_words[1];
      w2   <= key_words[2];
      w3   <= key_words[3];
      zidx <= '0;
    end else if (step) begin
      w0   <= w1;
      w1   <= w2;
      w2   <= w3;
      w3   <= w_next;
      zidx <= (zidx == ZIDX_BITS'(Z_LEN - 1)) ? '0 : zidx + 1'b1;
    end
  end

  assign key_word = w0;

endmodule

// ===== sv/sbc_round.sv =====
// sbc_round: digit-serial feistel datapath with the round key store
// depends on sbc_pkg for the control struct and word types

module sbc_round #(
  parameter int DIGIT_BITS = 8
) (
  input  logic              clk,
  input  sbc_pkg::rnd_ctrl_t ctrl,
  input  sbc_pkg::word_t    wr_data,
  input  sbc_pkg::word_t    blk_high,
  input  sbc_pkg::word_t    blk_low,
  output sbc_pkg::word_t    res_high,
  output sbc_pkg::word_t    res_low
);
  import sbc_pkg::*;

  word_t                 mem [ROUNDS];
  word_t                 kreg;
  word_t                 x, y, nx;
  word_t                 x_rot, y_next, nx_next;
  logic [DIGIT_BITS-1:0] f_digit, new_digit;

  always_comb begin
    for (int i = 0; i < DIGIT_BITS; i++) begin
      f_digit[i] = (x[(i + WORD_BITS - 1) % WORD_BITS] & x[(i + WORD_BITS - 8) % WORD_BITS])
                   ^ x[(i + WORD_BITS - 2) % WORD_BITS];
    end
    new_digit = y[DIGIT_BITS-1:0] ^ kreg[DIGIT_BITS-1:0] ^ f_digit;
    x_rot     = (x >> DIGIT_BITS) | (x << (WORD_BITS - DIGIT_BITS));
    y_next    = (y >> DIGIT_BITS)
                | (WORD_BITS'(x[DIGIT_BITS-1:0]) << (WORD_BITS - DIGIT_BITS));
    nx_next   = (nx >> DIGIT_BITS) | (WORD_BITS'(new_digit) << (WORD_BITS - DIGIT_BITS));
  end

  // round key store
  always_ff @(posedge clk) begin
    if (ctrl.key_wr) begin
      mem[ctrl.wr_addr] <= wr_data;
    end
    if (ctrl.key_rd) begin
      kreg <= mem[ctrl.key_addr];
    end else if (ctrl.step) begin
      kreg <= kreg >> DIGIT_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      x <= ctrl.swap ? blk_low : blk_high;
      y <= ctrl.swap ? blk_high : blk_low;
    end else if (ctrl.step) begin
      x  <= ctrl.last ? nx_next : x_rot;
      y  <= y_next;
      nx <= nx_next;
    end
  end

  assign res_high = ctrl.swap ? y : x;
  assign res_low  = ctrl.swap ? x : y;

endmodule

// ===== sv/simon_block_cipher_128_256_top.sv =====
// simon_block_cipher_128_256_top: simon 128/256 cipher, control, key registers, output stage
// depends on sbc_pkg, sbc_ifs, sbc_ksched and sbc_round
//
// usage:
//   cfg writes key words 0..3 (index 0 is the least significant quarter); any key
//   write marks the round keys stale; indexes above 3 are ignored. write keys only
//   while the block is idle.
//   blk takes one transaction: operation (0 encrypt, 1 decrypt) and a 128-bit block.
//   res returns one transaction with the 128-bit result per block.
// datapath: one block is worked in DIGIT_BITS-bit digits, one digit per cycle, round
//   after round; when the round keys are stale, the schedule is first run into the
//   store, one key per cycle, before the rounds start.
// overlap: blk is ready again as soon as the result moves to the output register, so
//   a new block runs while res holds the last result; blk takes no new block while
//   one is in the datapath.
// reset: returns to idle, drops res valid, clears key words to zero and marks the round keys stale.
// stall: if res is not taken, the finished block waits in the datapath until the
//   output register frees up; blk stays not ready meanwhile.

module simon_block_cipher_128_256_top #(
  parameter int DIGIT_BITS = 8
) (
  input logic      clk,
  input logic      rst,
  sbc_blk_if.sink  blk,
  sbc_res_if.source res,
  sbc_cfg_if.sink  cfg
);
  import sbc_pkg::*;

  localparam int DIGITS    = WORD_BITS / DIGIT_BITS;
  localparam int DCNT_BITS = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EXPAND = 5'b00010,
    S_PREP   = 5'b00100,
    S_ROUND  = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t               state;
  logic                 keys_valid;
  logic                 op;
  addr_t                rcnt, ecnt;
  logic [DCNT_BITS-1:0] dcnt;
  key_words_t           key_words;
  logic                 res_valid;
  word_t                result_high, result_low;
  rnd_ctrl_t            rctrl;
  word_t                ks_word, rnd_high, rnd_low;
  logic                 blk_acc, last_digit, last_round, res_free, cfg_key;

  assign blk.ready       = (state == S_IDLE);
  assign cfg.ready       = 1'b1;
  assign res.valid       = res_valid;
  assign res.result_high = result_high;
  assign res.result_low  = result_low;

  assign blk_acc    = blk.valid && blk.ready;
  assign last_digit = (dcnt == DCNT_BITS'(DIGITS - 1));
  assign last_round = (rcnt == ADDR_BITS'(ROUNDS - 1));
  assign res_free   = !res_valid || res.ready;
  assign cfg_key    = cfg.valid && cfg.ready &&
                      ((cfg.index == REG_KEY_WORD0) || (cfg.index == REG_KEY_WORD1) ||
                       (cfg.index == REG_KEY_WORD2) || (cfg.index == REG_KEY_WORD3));

  always_comb begin
    rctrl.load    = blk_acc;
    rctrl.swap    = blk_acc ? blk.operation : op;
    rctrl.step    = (state == S_ROUND);
    rctrl.last    = last_digit;
    rctrl.key_rd  = (state == S_PREP) || ((state == S_ROUND) && last_digit && !last_round);
    if (state == S_PREP) begin
      rctrl.key_addr = op ? ADDR_BITS'(ROUNDS - 1) : '0;
    end else begin
      rctrl.key_addr = op ? ADDR_BITS'(ROUNDS - 2) - rcnt : rcnt + 1'b1;
    end
    rctrl.key_wr  = (state == S_EXPAND);
    rctrl.wr_addr = ecnt;
  end

  sbc_ksched u_ksched (
    .clk       (clk),
    .load      (blk_acc),
    .step      (state == S_EXPAND),
    .key_words (key_words),
    .key_word  (ks_word)
  );

  sbc_round #(.DIGIT_BITS(DIGIT_BITS)) u_round (
    .clk      (clk),
    .ctrl     (rctrl),
    .wr_data  (ks_word),
    .blk_high (blk.block_high),
    .blk_low  (blk.block_low),
    .res_high (rnd_high),
    .res_low  (rnd_low)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      keys_valid <= 1'b0;
      res_valid  <= 1'b0;
      rcnt       <= '0;
      ecnt       <= '0;
      dcnt       <= '0;
      key_words  <= '0;
    end else begin
      if ((state == S_DONE) && res_free) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
      if (cfg_key) begin
        keys_valid <= 1'b0;
      end else if ((state == S_EXPAND) && (ecnt == ADDR_BITS'(ROUNDS - 1))) begin
        keys_valid <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (blk_acc) begin
            op    <= blk.operation;
            ecnt  <= '0;
            state <= keys_valid ? S_PREP : S_EXPAND;
          end
        end
        S_EXPAND: begin
          ecnt <= ecnt + 1'b1;
          if (ecnt == ADDR_BITS'(ROUNDS - 1)) begin
            state <= S_PREP;
          end
        end
        S_PREP: begin
          rcnt  <= '0;
          dcnt  <= '0;
          state <= S_ROUND;
        end
        S_ROUND: begin
          dcnt <= last_digit ? '0 : dcnt + 1'b1;
          if (last_digit) begin
            if (last_round) begin
              state <= S_DONE;
            end else begin
              rcnt <= rcnt + 1'b1;
            end
          end
        end
        S_DONE: begin
          if (res_free) begin
            result_high <= rnd_high;
            result_low  <= rnd_low;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_KEY_WORD0: begin
            key_words[0] <= cfg.data;
          end
          REG_KEY_WORD1: begin
            key_words[1] <= cfg.data;
          end
          REG_KEY_WORD2: begin
            key_words[2] <= cfg.data;
          end
          REG_KEY_WORD3: begin
            key_words[3] <= cfg.data;
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

// ===== sv/sbc_checker.sv =====
// sbc_checker: port-level assertions for the simon 128/256 cipher, bound to the top level
// depends on sbc_pkg and simon_block_cipher_128_256_top

module sbc_checker (
  input logic           clk,
  input logic           rst,
  input logic           blk_valid,
  input logic           blk_ready,
  input logic           res_valid,
  input logic           res_ready,
  input sbc_pkg::word_t res_high,
  input sbc_pkg::word_t res_low
);
  import sbc_pkg::*;

  // stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_high) && $stable(res_low))
    else $error("result changed while stalled");

  // busy after taking a block
  a_busy: assert property (@(posedge clk) disable iff (rst)
    blk_valid && blk_ready |=> !blk_ready)
    else $error("block taken while busy");

  // no result right after a block transaction
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    blk_valid && blk_ready |=> !$rose(res_valid))
    else $error("result appeared too early");

  // input side frees up when a result is handed over
  a_free: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> blk_ready)
    else $error("block channel not ready after result");

endmodule

bind simon_block_cipher_128_256_top sbc_checker u_sbc_checker (
  .clk       (clk),
  .rst       (rst),
  .blk_valid (blk.valid),
  .blk_ready (blk.ready),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .res_high  (res.result_high),
  .res_low   (res.result_low)
);
